>>> design/rvn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rvn_pkg
// shared types and constants of the rms vector normalizer
// ----------------------------------------------------------------------------
package rvn_pkg;

  localparam int DIV_N = 63;   // dividend / quotient width
  localparam int DIV_D = 38;   // divisor width
  localparam int RINV_W = 32;
  localparam logic [15:0] EPS_RESET = 16'd168;

  typedef struct packed {
    logic load;
    logic clear;
    logic div_mean;
    logic set_v;
    logic div_recip;
    logic rinv_zero;
    logic sqrt_start;
    logic emit_start;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic sqrt_done;
    logic emit_done;
    logic count_zero;
    logic v_zero;
  } stat_t;

endpackage
`default_nettype wire

>>> design/rvn_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rvn_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module rvn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> design/rvn_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rvn_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rvn_div (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [rvn_pkg::DIV_N-1:0] dividend,
  input  wire logic [rvn_pkg::DIV_D-1:0] divisor,
  output logic                           done,
  output logic      [rvn_pkg::DIV_N-1:0] quotient
);
  import rvn_pkg::*;

  localparam int CNT_W = $clog2(DIV_N);

  logic [DIV_D-1:0] rem;
  logic [DIV_D-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic             running;
  logic [DIV_D:0]   trial;
  logic             ge;

  assign trial = {rem, quotient[DIV_N-1]};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running  <= 1'b1;
        cnt      <= '0;
        rem      <= '0;
        dvs      <= divisor;
        quotient <= dividend;
      end else if (running) begin
        rem      <= ge ? DIV_D'(trial - {1'b0, dvs}) : trial[DIV_D-1:0];
        quotient <= {quotient[DIV_N-2:0], ge};
        cnt      <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(DIV_N - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> design/rvn_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rvn_ctrl
// sequencer: load, mean, reciprocal, square root, emit
// ----------------------------------------------------------------------------
module rvn_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic          is_last,
  input  wire rvn_pkg::stat_t stat,
  output rvn_pkg::cmd_t      cmd,
  output logic               busy
);
  import rvn_pkg::*;

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_MEAN  = 3'd2;
  localparam logic [2:0] S_VCHK  = 3'd3;
  localparam logic [2:0] S_RECIP = 3'd4;
  localparam logic [2:0] S_SQRT  = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign busy = state != S_LOAD;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_LOAD: begin
        if (start) begin
          cmd.load = 1'b1;
          if (is_last) state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.count_zero) begin
          cmd.clear  = 1'b1;
          state_next = S_LOAD;
        end else begin
          cmd.div_mean = 1'b1;
          state_next   = S_MEAN;
        end
      end
      S_MEAN: begin
        if (stat.div_done) begin
          cmd.set_v  = 1'b1;
          state_next = S_VCHK;
        end
      end
      S_VCHK: begin
        if (stat.v_zero) begin
          cmd.rinv_zero  = 1'b1;
          cmd.emit_start = 1'b1;
          state_next     = S_EMIT;
        end else begin
          cmd.div_recip = 1'b1;
          state_next    = S_RECIP;
        end
      end
      S_RECIP: begin
        if (stat.div_done) begin
          cmd.sqrt_start = 1'b1;
          state_next     = S_SQRT;
        end
      end
      S_SQRT: begin
        if (stat.sqrt_done) begin
          cmd.emit_start = 1'b1;
          state_next     = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat.emit_done) begin
          cmd.clear  = 1'b1;
          state_next = S_LOAD;
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

>>> design/rvn_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rvn_datapath
// vector store, energy accumulator, divider, square root and output pipe
// ----------------------------------------------------------------------------
module rvn_datapath #(
  parameter int MAX_LEN = 64
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire rvn_pkg::cmd_t       cmd,
  output rvn_pkg::stat_t           stat,
  input  wire logic signed [15:0]  activation,
  input  wire logic signed [15:0]  scale_weight,
  input  wire logic                cfg_we,
  input  wire logic        [15:0]  cfg_data,
  output logic                     result_valid,
  output logic signed      [15:0]  normalized,
  output logic                     final_flag,
  output logic                     truncated
);
  import rvn_pkg::*;

  localparam int AW = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 1);

  logic [15:0]       eps;
  logic [36:0]       square_sum;
  logic [CW-1:0]     count;
  logic              overflow_seen;
  logic [DIV_D-1:0]  v;
  logic [RINV_W-1:0] rinv;

  logic signed [31:0] sq;
  logic               room;
  assign sq   = activation * activation;
  assign room = count < CW'(MAX_LEN);

  // divider shared by the mean and the reciprocal
  logic             div_start;
  logic [DIV_N-1:0] div_dividend;
  logic [DIV_D-1:0] div_divisor;
  logic             div_done;
  logic [DIV_N-1:0] div_q;

  assign div_start    = cmd.div_mean | cmd.div_recip;
  assign div_dividend = cmd.div_mean ? DIV_N'(square_sum) : {1'b1, {(DIV_N - 1){1'b0}}};
  assign div_divisor  = cmd.div_mean ? DIV_D'(count) : v;

  rvn_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // vector store, activation in the upper half
  logic [31:0]   rd_data;
  logic [AW-1:0] rd_addr;

  rvn_ram #(.WIDTH(32), .DEPTH(MAX_LEN)) u_ram (
    .clk   (clk),
    .we    (cmd.load && room),
    .waddr (count[AW-1:0]),
    .wdata ({activation, scale_weight}),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      eps           <= EPS_RESET;
      square_sum    <= '0;
      count         <= '0;
      overflow_seen <= 1'b0;
    end else begin
      if (cfg_we) eps <= cfg_data;
      if (cmd.clear) begin
        square_sum    <= '0;
        count         <= '0;
        overflow_seen <= 1'b0;
      end else if (cmd.load) begin
        if (room) begin
          square_sum <= square_sum + 37'(unsigned'(sq));
          count      <= count + CW'(1);
        end else begin
          overflow_seen <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_v) v <= DIV_D'(div_q[36:0]) + DIV_D'(eps);
  end

  // bit-serial integer square root, two radicand bits per cycle
  logic             sq_run;
  logic             sqrt_done;
  logic [DIV_N-1:0] sx;
  logic [DIV_N-1:0] sres;
  logic [DIV_N-1:0] sbit;
  logic [DIV_N-1:0] trial;
  logic             sge;
  logic [DIV_N-1:0] sres_next;

  assign trial     = sres + sbit;
  assign sge       = sx >= trial;
  assign sres_next = sge ? ((sres >> 1) + sbit) : (sres >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_run    <= 1'b0;
      sqrt_done <= 1'b0;
    end else begin
      sqrt_done <= 1'b0;
      if (cmd.sqrt_start) begin
        sq_run <= 1'b1;
        sx     <= div_q;
        sres   <= '0;
        sbit   <= {1'b1, {(DIV_N - 1){1'b0}}};
      end else if (sq_run) begin
        if (sge) sx <= sx - trial;
        sres <= sres_next;
        sbit <= sbit >> 2;
        if (sbit[0]) begin
          sq_run    <= 1'b0;
          sqrt_done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rinv_zero) begin
      rinv <= '0;
    end else if (sq_run && sbit[0]) begin
      rinv <= sres_next[RINV_W-1:0];
    end
  end

  // output pipe: read, product, scale, round and saturate
  logic          issuing;
  logic [CW-1:0] rd_cnt;
  logic          rd_last;
  logic          v1, l1, v2, l2, v3, l3;
  logic signed [31:0] p;
  logic          neg3;
  logic [62:0]   prod;
  logic [30:0]   pmag;
  logic [62:0]   rnd;
  logic [31:0]   q;

  assign rd_addr = rd_cnt[AW-1:0];
  assign rd_last = rd_cnt == count - CW'(1);
  assign pmag    = p[31] ? 31'(-p) : p[30:0];
  assign rnd     = prod + {32'd0, 1'b1, 30'd0};
  assign q       = rnd[62:31];

  always_ff @(posedge clk) begin
    if (rst) begin
      issuing      <= 1'b0;
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.emit_start) begin
        issuing <= 1'b1;
        rd_cnt  <= '0;
      end else if (issuing) begin
        rd_cnt <= rd_cnt + CW'(1);
        if (rd_last) issuing <= 1'b0;
      end
      v1           <= issuing;
      v2           <= v1;
      v3           <= v2;
      result_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    l1   <= issuing && rd_last;
    l2   <= l1;
    p    <= $signed(rd_data[31:16]) * $signed(rd_data[15:0]);
    l3   <= l2;
    neg3 <= p[31];
    prod <= pmag * rinv;
    final_flag <= l3;
    truncated  <= overflow_seen;
    if (neg3) begin
      normalized <= (q > 32'd32768) ? -16'sd32768 : 16'(-q);
    end else begin
      normalized <= (q > 32'd32767) ? 16'sd32767 : q[15:0];
    end
  end

  assign stat.div_done   = div_done;
  assign stat.sqrt_done  = sqrt_done;
  assign stat.emit_done  = result_valid && final_flag;
  assign stat.count_zero = count == '0;
  assign stat.v_zero     = v == '0;

endmodule
`default_nettype wire

>>> design/rms_vector_normalizer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rms_vector_normalizer
// rms normalization of a weighted q4.12 vector
//
// channel   signals                                        direction
// request   start busy activation scale_weight is_last     in
// result    result_valid normalized final_flag truncated   out
// config    cfg_valid cfg_ready cfg_data (epsilon_code)    in
//
// loading takes one request per cycle while busy is low; the request marked
// last raises busy through the check, the mean division, the epsilon add,
// the reciprocal division (serial divider) and the square root, then the ram
// read and multiply pipe, which gives one result per cycle
// a zero sum of mean square and epsilon skips reciprocal and root
// results cannot be stalled
// synchronous reset clears counters and state; the store is not cleared
// ----------------------------------------------------------------------------
module rms_vector_normalizer #(
  parameter int MAX_LEN = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [15:0] activation,
  input  wire logic signed [15:0] scale_weight,
  input  wire logic               is_last,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic        [15:0] cfg_data,
  output logic                    result_valid,
  output logic signed      [15:0] normalized,
  output logic                    final_flag,
  output logic                    truncated
);
  import rvn_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  rvn_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .is_last (is_last),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  rvn_datapath #(.MAX_LEN(MAX_LEN)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .activation   (activation),
    .scale_weight (scale_weight),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .normalized   (normalized),
    .final_flag   (final_flag),
    .truncated    (truncated)
  );

`ifndef SYNTH
  a_result_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> busy) else $error("result outside busy");
  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && is_last |=> busy) else $error("last request did not set busy");
  a_final_gap: assert property (@(posedge clk) disable iff (rst)
    result_valid && final_flag |=> !result_valid) else $error("result after final");
`endif

endmodule
`default_nettype wire

>>> bench/rms_vector_normalizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rms_vector_normalizer_tb
// self-checking regression of the rms vector normalizer: directed corner
// vectors, zero energy, epsilon settings, buffer overflow and random vectors,
// with every result compared against a local fixed-point predictor
// ----------------------------------------------------------------------------
module rms_vector_normalizer_tb;
  import rvn_pkg::*;

  localparam int VEC_MAX = 64;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 300;

  typedef struct packed {
    logic signed [15:0] normalized;
    logic               final_flag;
    logic               truncated;
  } norm_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic signed [15:0] activation = '0;
  logic signed [15:0] scale_weight = '0;
  logic is_last = 1'b0;
  logic cfg_valid = 1'b0;
  logic [15:0] cfg_data = '0;
  logic busy, cfg_ready, result_valid, final_flag, truncated;
  logic signed [15:0] normalized;

  rms_vector_normalizer #(.MAX_LEN(VEC_MAX)) u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .activation(activation), .scale_weight(scale_weight), .is_last(is_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .result_valid(result_valid), .normalized(normalized),
    .final_flag(final_flag), .truncated(truncated)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic signed [15:0] act_mem [VEC_MAX];
  logic signed [15:0] wgt_mem [VEC_MAX];
  logic [36:0] sq_sum;
  int unsigned elem_cnt;
  logic dropped;
  logic [15:0] eps_model;
  norm_result_t norm_queue[$];

  int errors = 0;
  int requests_sent = 0;
  int vectors_sent = 0;
  int results_seen = 0;
  int cycles = 0;

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  task automatic predict_request(logic signed [15:0] a, logic signed [15:0] w, logic last);
    longint unsigned mag, v, rinv, q;
    longint signed p;
    norm_result_t r;
    if (elem_cnt < VEC_MAX) begin
      mag = (a < 0) ? -longint'(a) : longint'(a);
      act_mem[elem_cnt] = a;
      wgt_mem[elem_cnt] = w;
      sq_sum = sq_sum + 37'(mag * mag);
      elem_cnt++;
    end else begin
      dropped = 1'b1;
    end
    if (!last) return;
    if (elem_cnt != 0) begin
      v = longint'(sq_sum) / elem_cnt + eps_model;
      rinv = (v == 0) ? 0 : int_sqrt((64'd1 << 62) / v);
      for (int i = 0; i < elem_cnt; i++) begin
        p = longint'(act_mem[i]) * longint'(wgt_mem[i]);
        mag = (p < 0) ? -p : p;
        q = (mag * rinv + (64'd1 << 30)) >> 31;
        if (p < 0) r.normalized = (q > 32768) ? -16'sd32768 : 16'(-longint'(q));
        else r.normalized = (q > 32767) ? 16'sd32767 : 16'(q);
        r.final_flag = (i + 1 == elem_cnt);
        r.truncated = dropped;
        norm_queue.push_back(r);
      end
    end
    sq_sum = '0;
    elem_cnt = 0;
    dropped = 1'b0;
  endtask

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
  endtask

  // results cannot be stalled, so every strobe is checked as it comes
  always @(posedge clk) begin
    norm_result_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("rms_vector_normalizer regression: fail");
      $finish;
    end
    if (!rst && result_valid) begin
      results_seen++;
      if (norm_queue.size() == 0) begin
        report_mismatch("unexpected result, normalized", normalized, 0);
      end else begin
        want = norm_queue.pop_front();
        if (normalized !== want.normalized)
          report_mismatch("normalized", normalized, want.normalized);
        if (final_flag !== want.final_flag)
          report_mismatch("final_flag", final_flag, want.final_flag);
        if (truncated !== want.truncated)
          report_mismatch("truncated", truncated, want.truncated);
      end
    end
  end

  // one request after the given gap, start kept high when the gap is zero
  task automatic send_request(logic signed [15:0] a, logic signed [15:0] w, logic last,
                              int gap);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    activation <= a;
    scale_weight <= w;
    is_last <= last;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    predict_request(a, w, last);
    requests_sent++;
    if (last) vectors_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    wait (norm_queue.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_epsilon(logic [15:0] value);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    eps_model = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [15:0] rand_field();
    case ($urandom_range(0, 5))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return 16'($urandom_range(0, 8) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_vector(int len);
    for (int i = 0; i < len; i++)
      send_request(rand_field(), rand_field(), i == len - 1,
                   ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16));
  endtask

  task automatic test_corners();
    send_request(-16'sd32768, -16'sd32768, 1'b0, 0);
    send_request(16'sd32767, 16'sd32767, 1'b0, 0);
    send_request(-16'sd32768, 16'sd32767, 1'b0, 1);
    send_request(16'sd0, 16'sd0, 1'b0, 0);
    send_request(16'sd1, -16'sd1, 1'b1, 0);
    // single element vector
    send_request(16'sd4096, 16'sd4096, 1'b1, 3);
    // tiny energy with large weights
    send_request(16'sd1, 16'sd32767, 1'b0, 0);
    send_request(-16'sd1, -16'sd32768, 1'b1, 0);
  endtask

  task automatic test_zero_energy();
    write_epsilon(16'd0);
    for (int i = 0; i < 4; i++) send_request(16'sd0, rand_field(), i == 3, 0);
    send_request(16'sd1, 16'sd32767, 1'b0, 0);
    send_request(16'sd0, -16'sd32768, 1'b1, 0);
  endtask

  task automatic test_max_epsilon();
    write_epsilon(16'hffff);
    send_vector(6);
    for (int i = 0; i < 3; i++) send_request(16'sd2, 16'sd32767, i == 2, 0);
  endtask

  task automatic test_overflow();
    write_epsilon(16'd168);
    send_vector(VEC_MAX);
    send_vector(VEC_MAX + 4);
  endtask

  task automatic test_random();
    int sent;
    for (int phase = 0; phase < 4; phase++) begin
      write_epsilon((phase == 3) ? 16'd1 : 16'($urandom));
      sent = 0;
      while (sent < 24) begin
        int len;
        len = $urandom_range(1, 12);
        send_vector(len);
        sent += len;
      end
    end
  endtask

  initial begin
    for (int i = 0; i < VEC_MAX; i++) begin
      act_mem[i] = '0;
      wgt_mem[i] = '0;
    end
    sq_sum = '0;
    elem_cnt = 0;
    dropped = 1'b0;
    eps_model = EPS_RESET;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_corners();
    test_zero_energy();
    test_max_epsilon();
    test_overflow();
    test_random();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d requests in %0d vectors, %0d results checked, %0d mismatches",
             requests_sent, vectors_sent, results_seen, errors);
    if (errors == 0 && norm_queue.size() == 0) begin
      $display("rms_vector_normalizer regression: pass");
    end else begin
      $display("rms_vector_normalizer regression: fail");
    end
    $finish;
  end

endmodule

>>> rms_vector_normalizer.f
design/rvn_pkg.sv
design/rvn_ram.sv
design/rvn_div.sv
design/rvn_ctrl.sv
design/rvn_datapath.sv
design/rms_vector_normalizer.sv
bench/rms_vector_normalizer_tb.sv
